@@ sv/cdc_pkg.sv @@
// Shared types, codes and calendar tables for the date check pipeline.
// No dependencies; imported by every module of the block but the checker cdc_chk.
package cdc_pkg;

  // Daylight-saving season codes
  localparam logic [1:0] SEASON_WINTER = 2'd0;
  localparam logic [1:0] SEASON_SUMMER = 2'd1;
  localparam logic [1:0] SEASON_AMBIG  = 2'd2;

  // Raw input request fields
  typedef struct packed {
    logic [6:0] century_number;
    logic [6:0] year_in_century;
    logic [3:0] month_number;
    logic [4:0] day_of_month;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] sec;
  } raw_t;

  // After stage 1: full year and simple range checks
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  yc;
    logic [6:0]  c1;      // century minus one, zero for century zero
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [4:0]  hrs;
    logic        ok;      // all checks except day against month length
  } s1_t;

  // After stage 2: leap, month data and leap-day quotients
  typedef struct packed {
    logic [13:0] year;
    logic        leap;
    logic [4:0]  mlen;
    logic [8:0]  db;      // days before month
    logic [11:0] q4;
    logic [7:0]  q100;
    logic [5:0]  q400;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [4:0]  hrs;
    logic        valid;
  } s2_t;

  // One result
  typedef struct packed {
    logic        valid;
    logic [13:0] year;
    logic        leap;
    logic [4:0]  mlen;
    logic [2:0]  wd;
    logic [1:0]  season;
  } res_t;

  function automatic logic [4:0] month_days(input logic [3:0] mo);
    logic [4:0] r;
    case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Cumulative days before each month; months above 12 count a whole year
  function automatic logic [8:0] days_before(input logic [3:0] mo);
    logic [8:0] r;
    case (mo)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

@@ sv/cdc_year.sv @@
// Stage 1: full year from century and year fields, simple range checks.
// Depends on cdc_pkg.
module cdc_year
  import cdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  raw_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output s1_t  out_data
);

  logic valid_r;
  s1_t  data_r;
  s1_t  data_nxt;
  logic [6:0] c1;

  assign in_ready = !valid_r || out_ready;

  // century zero is taken as century one
  assign c1 = (in_data.century_number == 7'd0) ? 7'd0 : in_data.century_number - 7'd1;

  always_comb begin
    data_nxt.c1   = c1;
    data_nxt.yc   = in_data.year_in_century;
    // yc + 100 * c1 as shifts and adds
    data_nxt.year = 14'(in_data.year_in_century) + 14'({c1, 6'b0}) +
                    14'({c1, 5'b0}) + 14'({c1, 2'b0});
    data_nxt.day  = in_data.day_of_month;
    data_nxt.mon  = in_data.month_number;
    data_nxt.hrs  = in_data.hours;
    data_nxt.ok   = (in_data.sec < 6'd60) && (in_data.minutes < 6'd60) &&
                    (in_data.hours < 5'd24) && (in_data.month_number >= 4'd1) &&
                    (in_data.month_number <= 4'd12) && (in_data.day_of_month >= 5'd1) &&
                    (in_data.year_in_century <= 7'd99) && (in_data.century_number != 7'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ sv/cdc_month.sv @@
// Stage 2: leap year, month length, days before month, leap-day quotients.
// Depends on cdc_pkg.
module cdc_month
  import cdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_data
);

  logic valid_r;
  s2_t  data_r;
  s2_t  data_nxt;

  logic       hund;      // year is a multiple of 100
  logic       yc_hund;   // year_in_century is exactly 100
  logic [1:0] cq;        // year / 100, low bits
  logic       leap;
  logic [4:0] mlen;
  logic [7:0] v100;
  logic [9:0] w400;
  logic [1:0] f100;
  logic [1:0] f400;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    // year = 100*c1 + yc with yc below 128, so only yc 0 or 100 hit a century
    yc_hund = (in_data.yc == 7'd100);
    hund    = (in_data.yc == 7'd0) || yc_hund;
    cq      = in_data.c1[1:0] + {1'b0, yc_hund};
    leap    = (in_data.yc[1:0] == 2'd0) && !(hund && (cq != 2'd0));
    mlen    = (in_data.mon == 4'd2) ? (leap ? 5'd29 : 5'd28) : month_days(in_data.mon);

    // (year + 99) / 100 = c1 + (yc + 99) / 100
    v100 = 8'(in_data.yc) + 8'd99;
    f100 = (v100 >= 8'd200) ? 2'd2 : ((v100 >= 8'd100) ? 2'd1 : 2'd0);
    // (year + 399) / 400 = c1/4 + (100*(c1%4) + yc + 399) / 400
    w400 = 10'({in_data.c1[1:0], 6'b0}) + 10'({in_data.c1[1:0], 5'b0}) +
           10'({in_data.c1[1:0], 2'b0}) + 10'(in_data.yc) + 10'd399;
    f400 = (w400 >= 10'd800) ? 2'd2 : ((w400 >= 10'd400) ? 2'd1 : 2'd0);

    data_nxt.year  = in_data.year;
    data_nxt.leap  = leap;
    data_nxt.mlen  = mlen;
    data_nxt.db    = days_before(in_data.mon);
    data_nxt.q4    = 12'((15'(in_data.year) + 15'd3) >> 2);
    data_nxt.q100  = 8'(in_data.c1) + 8'(f100);
    data_nxt.q400  = 6'(in_data.c1[6:2]) + 6'(f400);
    data_nxt.day   = in_data.day;
    data_nxt.mon   = in_data.mon;
    data_nxt.hrs   = in_data.hrs;
    data_nxt.valid = in_data.ok && (in_data.day <= mlen);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ sv/cdc_wkday.sv @@
// Stages 3 and 4: day count modulo 7, weekday, DST season and output register.
// Depends on cdc_pkg.
module cdc_wkday
  import cdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  s2_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  // stage 3 registers
  logic        v3_r;
  logic [14:0] sum_r;
  logic [14:0] sum_nxt;
  logic [4:0]  day_r;
  logic [3:0]  mon_r;
  logic [4:0]  hrs_r;
  res_t        part_r;
  res_t        part_nxt;
  logic        rdy3;

  // stage 4 registers
  logic        v4_r;
  res_t        res_r;
  res_t        res_nxt;
  logic        rdy4;

  logic        ladd;
  logic [5:0]  t1;
  logic [3:0]  t2;
  logic [2:0]  rem;
  logic [2:0]  wd;
  logic        on_day;
  logic        after_chg;
  logic [1:0]  season;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign in_ready = rdy3;

  // Stage 3: 365 is 1 mod 7, so the year counts once; add leap days and month offset
  always_comb begin
    ladd    = (in_data.mon > 4'd2) && in_data.leap;
    sum_nxt = 15'(in_data.year) + 15'(in_data.q4) - 15'(in_data.q100) +
              15'(in_data.q400) + 15'(in_data.db) + 15'(ladd) +
              15'(in_data.day) + 15'd4;
    part_nxt        = '0;
    part_nxt.valid  = in_data.valid;
    part_nxt.year   = in_data.year;
    part_nxt.leap   = in_data.leap;
    part_nxt.mlen   = in_data.mlen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      sum_r  <= sum_nxt;
      day_r  <= in_data.day;
      mon_r  <= in_data.mon;
      hrs_r  <= in_data.hrs;
      part_r <= part_nxt;
    end
  end

  // Stage 4: modulo 7 by folding octal digits (8 is 1 mod 7), then season
  always_comb begin
    t1  = 6'(sum_r[2:0]) + 6'(sum_r[5:3]) + 6'(sum_r[8:6]) +
          6'(sum_r[11:9]) + 6'(sum_r[14:12]);
    t2  = 4'(t1[2:0]) + 4'(t1[5:3]);
    rem = (t2 >= 4'd7) ? 3'(t2 - 4'd7) : t2[2:0];
    wd  = rem + 3'd1;

    // last Sunday of the month is day 25 or later
    on_day    = (wd == 3'd7) && (day_r >= 5'd25);
    after_chg = (wd != 3'd7) && (6'(day_r) >= 6'(wd) + 6'd25);

    if ((mon_r < 4'd3) || (mon_r > 4'd10)) begin
      season = SEASON_WINTER;
    end else if ((mon_r > 4'd3) && (mon_r < 4'd10)) begin
      season = SEASON_SUMMER;
    end else if (mon_r == 4'd3) begin
      // March: summer from 02:00 on the last Sunday
      season = (after_chg || (on_day && (hrs_r >= 5'd2))) ? SEASON_SUMMER : SEASON_WINTER;
    end else if (after_chg) begin
      season = SEASON_WINTER;
    end else if (on_day) begin
      // October: the 02:00 hour happens twice
      if (hrs_r < 5'd2) begin
        season = SEASON_SUMMER;
      end else if (hrs_r >= 5'd3) begin
        season = SEASON_WINTER;
      end else begin
        season = SEASON_AMBIG;
      end
    end else begin
      season = SEASON_SUMMER;
    end

    res_nxt        = part_r;
    res_nxt.wd     = wd;
    res_nxt.season = season;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = res_r;

endmodule

@@ sv/calendar_date_check_weekday_dst.sv @@
// Calendar date check, weekday and EU daylight-saving season, four-stage pipeline.
// Throughput one request per cycle while the output is not stalled, set by the four
// registered stages with ready passed back.
// A stalled output holds its result and back-pressures each stage that holds a request.
// Reset (rst_n low, synchronous) clears all stage valid bits; data regs not reset.
// Depends on cdc_pkg, cdc_year, cdc_month, cdc_wkday.
module calendar_date_check_weekday_dst
  import cdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sec[5:0], minutes[11:6], hours[16:12], day_of_month[21:17],
  // month_number[25:22], year_in_century[32:26], century_number[39:33]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // full_year[13:0], is_leap[14], month_length[19:15], week_day[22:20],
  // dst_season[24:23], zero[31:25]
  output logic [31:0] out_tdata,
  // fields_valid[0]
  output logic        out_tuser
);

  raw_t raw;
  s1_t  s1;
  s2_t  s2;
  res_t res;
  logic v1, v2, r1, r2;

  assign raw.sec             = in_tdata[5:0];
  assign raw.minutes         = in_tdata[11:6];
  assign raw.hours           = in_tdata[16:12];
  assign raw.day_of_month    = in_tdata[21:17];
  assign raw.month_number    = in_tdata[25:22];
  assign raw.year_in_century = in_tdata[32:26];
  assign raw.century_number  = in_tdata[39:33];

  cdc_year u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (raw),
    .out_valid (v1),
    .out_ready (r1),
    .out_data  (s1)
  );

  cdc_month u_month (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1),
    .in_ready  (r1),
    .in_data   (s1),
    .out_valid (v2),
    .out_ready (r2),
    .out_data  (s2)
  );

  cdc_wkday u_wkday (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2),
    .in_ready  (r2),
    .in_data   (s2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {7'b0, res.season, res.wd, res.mlen, res.leap, res.year};
  assign out_tuser = res.valid;

endmodule

@@ sv/cdc_chk.sv @@
// Port-level checker for the date check block, bound to the top level.
// Depends on calendar_date_check_weekday_dst ports only.
module cdc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // stalled result request holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output request changed while stalled");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // weekday is never zero
  a_wd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:20] != 3'd0)
    else $error("weekday zero");

  // season code 3 never appears
  a_season: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[24:23] != 2'd3)
    else $error("bad season code");

  // a valid date has a real month and a year below 10000
  a_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[19:15] >= 5'd28 && out_tdata[13:0] <= 14'd9999)
    else $error("valid date with bad month length or year");

endmodule

bind calendar_date_check_weekday_dst cdc_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ dv/tb_calendar_date_check_weekday_dst.sv @@
// Testbench for the calendar date check: validity, full year, leap year, month
// length, weekday and EU daylight-saving season, checked against a local model.
// Depends on cdc_pkg and calendar_date_check_weekday_dst; self-contained otherwise.
module tb_calendar_date_check_weekday_dst;
  import cdc_pkg::*;

  localparam int RANDOM_ITEMS = 1550;

  // One expected result, in the order the fields leave the block
  typedef struct packed {
    logic        valid;
    logic [13:0] year;
    logic        leap;
    logic [4:0]  mlen;
    logic [2:0]  wd;
    logic [1:0]  season;
  } cal_result_t;

  // Directed stimulus row; known rows carry a hand-written result
  typedef struct packed {
    raw_t        req;
    logic        known;
    cal_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  cal_result_t expected_results[$];
  stim_row_t   stim_rows[$];
  int          error_count = 0;
  int          sent_count = 0;
  int          result_count = 0;

  calendar_date_check_weekday_dst dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- calendar math

  function automatic int full_year_of(input int century, input int yc);
    return yc + 100 * ((century != 0) ? century - 1 : 0);
  endfunction

  function automatic bit is_leap_year(input int year);
    return (year % 4 == 0) && !((year % 100 == 0) && (year % 400 != 0));
  endfunction

  // Days in month; zero outside 1..12
  function automatic int month_len(input int mo, input bit leap);
    int n;
    case (mo)
      2:              n = leap ? 29 : 28;
      4, 6, 9, 11:    n = 30;
      1, 3, 5, 7, 8,
      10, 12:         n = 31;
      default:        n = 0;
    endcase
    return n;
  endfunction

  // Expected result of one date request
  function automatic cal_result_t predict_calendar(input raw_t r);
    cal_result_t res;
    int          year, mlen, days, wd, mo, d, h, m;
    bit          leap, on_sunday, past_change;
    mo   = int'(r.month_number);
    d    = int'(r.day_of_month);
    h    = int'(r.hours);
    year = full_year_of(int'(r.century_number), int'(r.year_in_century));
    leap = is_leap_year(year);
    mlen = month_len(mo, leap);

    // whole days since year zero; invalid months above 12 add nothing past December
    days = 365 * year + (year + 3) / 4 - (year + 99) / 100 + (year + 399) / 400;
    for (m = 1; m < mo; m++) days += month_len(m, 1'b0);
    if (mo > 2 && leap) days += 1;
    days += d;
    wd = 1 + (days + 4) % 7;

    res.valid = int'(r.sec) < 60 && int'(r.minutes) < 60 && h < 24 && mo >= 1 &&
                mo <= 12 && d >= 1 && int'(r.year_in_century) <= 99 &&
                int'(r.century_number) != 0 && d <= mlen;
    res.year  = year[13:0];
    res.leap  = leap;
    res.mlen  = mlen[4:0];
    res.wd    = wd[2:0];

    // EU season: switch on the last Sunday of March and October
    on_sunday   = (wd == 7) && (d >= 25);
    past_change = (wd != 7) && (d - wd >= 25);
    if (mo < 3 || mo > 10)
      res.season = SEASON_WINTER;
    else if (mo > 3 && mo < 10)
      res.season = SEASON_SUMMER;
    else if (mo == 3)
      res.season = (past_change || (on_sunday && h >= 2)) ? SEASON_SUMMER : SEASON_WINTER;
    else if (past_change)
      res.season = SEASON_WINTER;
    else if (on_sunday)
      res.season = (h < 2) ? SEASON_SUMMER : (h >= 3) ? SEASON_WINTER : SEASON_AMBIG;
    else
      res.season = SEASON_SUMMER;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // Fields given most significant first, as a date reads
  function automatic raw_t mk(input int c, input int yc, input int mo, input int d,
                              input int h, input int mi, input int s);
    raw_t r;
    r.century_number  = 7'(c);
    r.year_in_century = 7'(yc);
    r.month_number    = 4'(mo);
    r.day_of_month    = 5'(d);
    r.hours           = 5'(h);
    r.minutes         = 6'(mi);
    r.sec             = 6'(s);
    return r;
  endfunction

  function automatic cal_result_t mkres(input int v, input int y, input int l,
                                        input int ml, input int wd, input logic [1:0] se);
    cal_result_t res;
    res.valid  = (v != 0);
    res.year   = 14'(y);
    res.leap   = (l != 0);
    res.mlen   = 5'(ml);
    res.wd     = 3'(wd);
    res.season = se;
    return res;
  endfunction

  function automatic void add_row(input raw_t r, input int known, input cal_result_t want);
    stim_rows.push_back({r, known != 0, want});
  endfunction

  // Mostly well-formed dates, weighted to the season change weeks, plus broken fields
  function automatic raw_t random_request();
    raw_t r;
    int   lim, pick;
    bit   edge_week;
    r.century_number  = 7'($urandom_range(1, 100));
    r.year_in_century = 7'($urandom_range(0, 99));
    edge_week = ($urandom_range(0, 2) == 0);
    if (edge_week)
      r.month_number = $urandom_range(0, 1) ? 4'd3 : 4'd10;
    else
      r.month_number = 4'($urandom_range(1, 12));
    lim = month_len(int'(r.month_number),
                    is_leap_year(full_year_of(int'(r.century_number),
                                              int'(r.year_in_century))));
    r.day_of_month = 5'(edge_week ? $urandom_range(22, 31) : $urandom_range(1, lim));
    r.hours        = 5'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 23));
    r.minutes      = 6'($urandom_range(0, 59));
    r.sec          = 6'($urandom_range(0, 59));

    pick = $urandom_range(0, 99);
    if (pick >= 72) begin
      case ($urandom_range(0, 7))
        0: r.sec = 6'($urandom_range(60, 63));
        1: r.minutes = 6'($urandom_range(60, 63));
        2: r.hours = 5'($urandom_range(24, 31));
        3: r.day_of_month = (lim < 31 && $urandom_range(0, 1)) ?
                            5'($urandom_range(lim + 1, 31)) : 5'd0;
        4: r.month_number = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
        5: r.year_in_century = 7'($urandom_range(100, 127));
        6: r.century_number = 7'd0;
        default: begin
          r.sec             = 6'($urandom_range(0, 63));
          r.minutes         = 6'($urandom_range(0, 63));
          r.hours           = 5'($urandom_range(0, 31));
          r.day_of_month    = 5'($urandom_range(0, 31));
          r.month_number    = 4'($urandom_range(0, 15));
          r.year_in_century = 7'($urandom_range(0, 127));
          r.century_number  = 7'($urandom_range(0, 100));
        end
      endcase
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request and hold it until accepted, then log what should come out
  task automatic send_request(input raw_t r, input bit known, input cal_result_t want);
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(known ? want : predict_calendar(r));
    sent_count++;
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR result %0d %s: got %0d, expected %0d", result_count, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin
    int i, gap;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: century, yc, month, day, hour, minute, second
    add_row(mk(21, 0, 1, 1, 0, 0, 0), 1, mkres(1, 2000, 1, 31, 6, SEASON_WINTER));
    add_row(mk(20, 0, 1, 1, 0, 0, 0), 1, mkres(1, 1900, 0, 31, 1, SEASON_WINTER));
    // century zero falls back to year in century alone
    add_row(mk(0, 0, 1, 1, 0, 0, 0), 1, mkres(0, 0, 1, 31, 6, SEASON_WINTER));
    add_row(mk(0, 0, 0, 0, 0, 0, 0), 1, mkres(0, 0, 1, 0, 5, SEASON_WINTER));
    add_row(mk(100, 127, 15, 31, 31, 63, 63), 0, '0);
    add_row(mk(100, 99, 12, 31, 23, 59, 59), 0, '0);
    // leap day in a plain century, a 400-year century, a leap and a common year
    add_row(mk(20, 0, 2, 29, 12, 0, 0), 0, '0);
    add_row(mk(21, 0, 2, 29, 12, 0, 0), 0, '0);
    add_row(mk(21, 24, 2, 29, 12, 0, 0), 0, '0);
    add_row(mk(21, 23, 2, 29, 12, 0, 0), 0, '0);
    add_row(mk(21, 24, 13, 1, 0, 0, 0), 0, '0);
    // last Sunday of March 2023 is the 26th
    add_row(mk(21, 23, 3, 26, 1, 59, 59), 0, '0);
    add_row(mk(21, 23, 3, 26, 2, 0, 0), 0, '0);
    add_row(mk(21, 23, 3, 27, 0, 0, 0), 0, '0);
    add_row(mk(21, 23, 3, 25, 23, 0, 0), 0, '0);
    // last Sunday of October 2023 is the 29th; hour 2 repeats
    add_row(mk(21, 23, 10, 29, 1, 59, 59), 0, '0);
    add_row(mk(21, 23, 10, 29, 2, 30, 0), 0, '0);
    add_row(mk(21, 23, 10, 29, 3, 0, 0), 0, '0);
    add_row(mk(21, 23, 10, 29, 31, 0, 0), 0, '0);
    add_row(mk(21, 23, 10, 30, 12, 0, 0), 0, '0);
    add_row(mk(21, 23, 10, 24, 12, 0, 0), 0, '0);
    add_row(mk(21, 23, 6, 15, 12, 0, 0), 0, '0);
    add_row(mk(21, 23, 6, 15, 12, 0, 60), 0, '0);
    add_row(mk(21, 23, 6, 15, 12, 60, 0), 0, '0);
    add_row(mk(21, 100, 1, 1, 24, 0, 0), 0, '0);

    foreach (stim_rows[k]) begin
      idle_sender(idle_cycles());
      send_request(stim_rows[k].req, stim_rows[k].known, stim_rows[k].want);
    end

    // let the directed part drain before the random part
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // back-to-back stretches: around the long receiver hold-off and a calm window
      if ((sent_count >= 200 && sent_count < 500) || (sent_count >= 1000 && sent_count < 1150))
        gap = 0;
      else
        gap = idle_cycles();
      if (i == 700) begin
        in_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end else begin
        idle_sender(gap);
      end
      send_request(random_request(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // Receiver: random stalls, one long hold-off while requests keep coming
  initial begin
    int  gap;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sent_count >= 250) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
      end else begin
        gap = (sent_count >= 1000 && sent_count < 1150) ? 0 : idle_cycles();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cal_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, none pending", int'(out_tdata[13:0]), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.valid)
          report_mismatch("fields_valid", int'(out_tuser), int'(want.valid));
        if (out_tdata[13:0] !== want.year)
          report_mismatch("full_year", int'(out_tdata[13:0]), int'(want.year));
        if (out_tdata[14] !== want.leap)
          report_mismatch("is_leap", int'(out_tdata[14]), int'(want.leap));
        if (out_tdata[19:15] !== want.mlen)
          report_mismatch("month_length", int'(out_tdata[19:15]), int'(want.mlen));
        if (out_tdata[22:20] !== want.wd)
          report_mismatch("week_day", int'(out_tdata[22:20]), int'(want.wd));
        if (out_tdata[24:23] !== want.season)
          report_mismatch("dst_season", int'(out_tdata[24:23]), int'(want.season));
        if (out_tdata[31:25] !== 7'd0)
          report_mismatch("pad bits", int'(out_tdata[31:25]), 0);
      end
      result_count++;
    end
  end

  // Run limit
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cdc_pkg.sv
sv/cdc_year.sv
sv/cdc_month.sv
sv/cdc_wkday.sv
sv/calendar_date_check_weekday_dst.sv
sv/cdc_chk.sv
dv/tb_calendar_date_check_weekday_dst.sv
